// File: rtl/core/hhlp_pkg.sv
`default_nettype none

package hhlp_pkg;

    // Width of the shared key/value position counter.
    localparam int POS_W = 13;
    localparam int KEY_LIMIT_W = 9;
    localparam int VALUE_LIMIT_W = 13;

    // Configuration register map (index = byte address / 4).
    localparam int APB_ADDR_W = 3;
    localparam logic REG_KEY_LIMIT = 1'b0;
    localparam logic REG_VALUE_LIMIT = 1'b1;
    localparam logic [KEY_LIMIT_W-1:0] KEY_LIMIT_RESET = 9'd256;
    localparam logic [VALUE_LIMIT_W-1:0] VALUE_LIMIT_RESET = 13'd1024;

    // Byte classification codes.
    localparam logic [2:0] KIND_KEY = 3'd0;
    localparam logic [2:0] KIND_COLON = 3'd1;
    localparam logic [2:0] KIND_SPACE = 3'd2;
    localparam logic [2:0] KIND_VALUE = 3'd3;
    localparam logic [2:0] KIND_DONE = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;
    localparam logic [2:0] KIND_IGNORED = 3'd6;

    // Characters that steer the parse.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
        logic       block_end;
    } hhlp_in_t;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  echo_byte;
        logic [11:0] field_position;
        logic [5:0]  headers_done;
        logic        is_block_end;
        logic        block_status;
    } hhlp_out_t;

    // Per-block parse state; the header count lives beside it since its
    // width follows the table size.
    typedef struct packed {
        logic             in_value_phase;
        logic [POS_W-1:0] position_count;
        logic [7:0]       previous_byte;
        logic             error_latched;
    } hhlp_state_t;

endpackage

`default_nettype wire

// File: rtl/core/hhlp_classifier.sv
`default_nettype none

module hhlp_classifier
    import hhlp_pkg::*;
#(
    parameter int KEY_BOUND = 256,
    parameter int VALUE_BOUND = 4096,
    parameter int MAX_HEADERS = 32,
    parameter int HDR_W = $clog2(MAX_HEADERS + 1)
) (
    input  wire hhlp_in_t                 in_item,
    input  wire hhlp_state_t              state_cur,
    input  wire logic [HDR_W-1:0]         hdr_cur,
    input  wire logic [KEY_LIMIT_W-1:0]   key_limit,
    input  wire logic [VALUE_LIMIT_W-1:0] value_limit,
    output hhlp_state_t                   state_next,
    output logic [HDR_W-1:0]              hdr_next,
    output hhlp_out_t                     result
);

    // Compare width covers the largest bound and both register widths.
    localparam int CMP_W = 17;
    localparam logic [CMP_W-1:0] KEY_BOUND_C = CMP_W'(KEY_BOUND);
    localparam logic [CMP_W-1:0] VALUE_BOUND_C = CMP_W'(VALUE_BOUND);
    localparam logic [HDR_W-1:0] MAX_HEADERS_C = HDR_W'(MAX_HEADERS);

    hhlp_state_t      st;
    hhlp_state_t      nst;
    logic [HDR_W-1:0] hdr;
    logic [HDR_W-1:0] nhdr;
    logic [CMP_W-1:0] klim;
    logic [CMP_W-1:0] vlim;
    logic [CMP_W-1:0] p_ext;
    logic [POS_W-1:0] pos;
    logic [2:0]       kind;
    logic [7:0]       b;

    // Classify one byte against the current state and work out the next state.
    always_comb begin
        b = in_item.data_byte;
        st = in_item.block_start ? '0 : state_cur;
        hdr = in_item.block_start ? '0 : hdr_cur;

        klim = (CMP_W'(key_limit) < KEY_BOUND_C) ? CMP_W'(key_limit) : KEY_BOUND_C;
        vlim = (CMP_W'(value_limit) < VALUE_BOUND_C) ? CMP_W'(value_limit) : VALUE_BOUND_C;
        p_ext = CMP_W'(st.position_count);

        nst = st;
        nhdr = hdr;
        kind = KIND_IGNORED;
        pos = '0;

        if (st.error_latched) begin
            kind = KIND_IGNORED;
        end else if (!st.in_value_phase) begin
            // Key phase: characters up to the colon.
            pos = st.position_count;
            if (p_ext >= klim || b == CHAR_CR || b == CHAR_LF) begin
                kind = KIND_ERROR;
            end else if (b == CHAR_COLON) begin
                if (st.position_count == '0 || st.previous_byte == CHAR_SPACE) begin
                    kind = KIND_ERROR;
                end else begin
                    kind = KIND_COLON;
                    nst.in_value_phase = 1'b1;
                    nst.position_count = '0;
                end
            end else begin
                kind = KIND_KEY;
                nst.position_count = st.position_count + POS_W'(1);
            end
        end else begin
            // Value phase: leading space, value bytes, then CR LF.
            pos = st.position_count;
            if (p_ext >= vlim) begin
                kind = KIND_ERROR;
            end else if (st.position_count == '0) begin
                if (b == CHAR_SPACE) begin
                    kind = KIND_SPACE;
                    nst.position_count = POS_W'(1);
                end else begin
                    kind = KIND_ERROR;
                end
            end else if (b == CHAR_LF) begin
                if (st.position_count < POS_W'(2) || st.previous_byte != CHAR_CR ||
                    hdr >= MAX_HEADERS_C) begin
                    kind = KIND_ERROR;
                end else begin
                    kind = KIND_DONE;
                    pos = st.position_count - POS_W'(2);
                    nhdr = hdr + HDR_W'(1);
                    nst.in_value_phase = 1'b0;
                    nst.position_count = '0;
                end
            end else begin
                kind = KIND_VALUE;
                nst.position_count = st.position_count + POS_W'(1);
            end
        end

        if (kind == KIND_ERROR) begin
            nst.error_latched = 1'b1;
        end
        if (kind != KIND_IGNORED) begin
            nst.previous_byte = b;
        end

        result.byte_kind = kind;
        result.echo_byte = b;
        result.field_position = pos[11:0];
        result.headers_done = 6'(nhdr);
        result.is_block_end = in_item.block_end;
        result.block_status = nst.error_latched;

        // The last byte of a block leaves the parser clean for the next one.
        if (in_item.block_end) begin
            state_next = '0;
            hdr_next = '0;
        end else begin
            state_next = nst;
            hdr_next = nhdr;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/http_header_line_parser.sv
`default_nettype none

// HTTP header line parser. Takes one header byte per transaction on the s_ channel and
// returns one classified byte per transaction on the m_ channel, in order: key byte, colon,
// leading space, value byte, header done, error or ignored, with its position, the running
// header count and the block status. An item is classified in the cycle it is accepted and
// its result sits in the output register in the next cycle; the block sustains one byte per
// clock while the sink keeps m_ready high, set by the single output register, and s_ready
// stays high while that register is empty or being drained. Registers on the APB port:
// key_length_limit at byte address 0x0 (9 bits, reset 256) and value_length_limit at 0x4
// (13 bits, reset 1024); write them only while no transaction is in flight.
module http_header_line_parser
    import hhlp_pkg::*;
#(
    parameter int KEY_BOUND = 256,
    parameter int VALUE_BOUND = 4096,
    parameter int MAX_HEADERS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire hhlp_in_t              s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output hhlp_out_t                  m_data,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int HDR_W = $clog2(MAX_HEADERS + 1);

    hhlp_state_t              state_reg;
    hhlp_state_t              state_next;
    logic [HDR_W-1:0]         hdr_reg;
    logic [HDR_W-1:0]         hdr_next;
    logic                     m_valid_reg;
    hhlp_out_t                m_data_reg;
    hhlp_out_t                result;
    logic [KEY_LIMIT_W-1:0]   key_limit_reg;
    logic [VALUE_LIMIT_W-1:0] value_limit_reg;
    logic                     in_accept;
    logic                     cfg_write;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    hhlp_classifier #(
        .KEY_BOUND   (KEY_BOUND),
        .VALUE_BOUND (VALUE_BOUND),
        .MAX_HEADERS (MAX_HEADERS),
        .HDR_W       (HDR_W)
    ) u_classifier (
        .in_item     (s_data),
        .state_cur   (state_reg),
        .hdr_cur     (hdr_reg),
        .key_limit   (key_limit_reg),
        .value_limit (value_limit_reg),
        .state_next  (state_next),
        .hdr_next    (hdr_next),
        .result      (result)
    );

    // Parse state advances on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            hdr_reg <= '0;
        end else if (in_accept) begin
            state_reg <= state_next;
            hdr_reg <= hdr_next;
        end
    end

    // Output register: loads on accept, empties when the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= result;
        end
    end

    // Configuration registers, decoded on the word address bit.
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_limit_reg <= KEY_LIMIT_RESET;
            value_limit_reg <= VALUE_LIMIT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_KEY_LIMIT: begin
                    key_limit_reg <= pwdata[KEY_LIMIT_W-1:0];
                end
                REG_VALUE_LIMIT: begin
                    value_limit_reg <= pwdata[VALUE_LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_KEY_LIMIT: begin
                prdata = 32'(key_limit_reg);
            end
            REG_VALUE_LIMIT: begin
                prdata = 32'(value_limit_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps

import hhlp_pkg::*;

// Scoreboard for the header line parser. It keeps its own copy of the parse
// state and the two length limits, predicts the result of every accepted byte,
// and matches the results from the block against those predictions in order.
class header_line_scoreboard;
    int key_bound;
    int value_bound;
    int max_headers;

    logic [KEY_LIMIT_W-1:0]   key_limit;
    logic [VALUE_LIMIT_W-1:0] value_limit;

    bit         in_value;
    int         pos_count;
    logic [7:0] prev_byte;
    bit         err_latched;
    int         header_total;

    hhlp_out_t expected_results[$];
    int        mismatch_count;
    int        accepted_count;

    function new(int kb, int vb, int mh);
        key_bound = kb;
        value_bound = vb;
        max_headers = mh;
        key_limit = KEY_LIMIT_RESET;
        value_limit = VALUE_LIMIT_RESET;
        mismatch_count = 0;
        accepted_count = 0;
        clear_block();
    endfunction

    function void clear_block();
        in_value = 1'b0;
        pos_count = 0;
        prev_byte = 8'h00;
        err_latched = 1'b0;
        header_total = 0;
    endfunction

    // Classify one byte and advance the parse state.
    function hhlp_out_t classify_byte(hhlp_in_t item);
        hhlp_out_t  r;
        logic [2:0] kind;
        logic [7:0] b;
        int         klim;
        int         vlim;
        int         p;
        int         pos;
        b = item.data_byte;
        klim = (key_limit < key_bound) ? key_limit : key_bound;
        vlim = (value_limit < value_bound) ? value_limit : value_bound;
        pos = 0;
        if (item.block_start) begin
            clear_block();
        end
        p = pos_count;

        if (err_latched) begin
            kind = KIND_IGNORED;
        end else if (!in_value) begin
            // Key phase: a colon closes a non-empty key with no space before it.
            pos = p;
            if (p >= klim || b == CHAR_CR || b == CHAR_LF) begin
                kind = KIND_ERROR;
            end else if (b == CHAR_COLON) begin
                if (p == 0 || prev_byte == CHAR_SPACE) begin
                    kind = KIND_ERROR;
                end else begin
                    kind = KIND_COLON;
                    in_value = 1'b1;
                    pos_count = 0;
                end
            end else begin
                kind = KIND_KEY;
                pos_count = p + 1;
            end
        end else begin
            // Value phase: leading space, value bytes, then CR LF completes it.
            pos = p;
            if (p >= vlim) begin
                kind = KIND_ERROR;
            end else if (p == 0) begin
                if (b == CHAR_SPACE) begin
                    kind = KIND_SPACE;
                    pos_count = 1;
                end else begin
                    kind = KIND_ERROR;
                end
            end else if (b == CHAR_LF) begin
                if (p < 2 || prev_byte != CHAR_CR || header_total >= max_headers) begin
                    kind = KIND_ERROR;
                end else begin
                    kind = KIND_DONE;
                    pos = p - 2;
                    header_total++;
                    in_value = 1'b0;
                    pos_count = 0;
                end
            end else begin
                kind = KIND_VALUE;
                pos_count = p + 1;
            end
        end

        if (kind == KIND_ERROR) begin
            err_latched = 1'b1;
        end
        if (kind != KIND_IGNORED) begin
            prev_byte = b;
        end

        r.byte_kind = kind;
        r.echo_byte = b;
        r.field_position = pos[11:0];
        r.headers_done = header_total[5:0];
        r.is_block_end = item.block_end;
        r.block_status = err_latched;

        if (item.block_end) begin
            clear_block();
        end
        return r;
    endfunction

    function void note_input(hhlp_in_t item);
        hhlp_out_t r;
        r = classify_byte(item);
        accepted_count++;
        expected_results.push_back(r);
    endfunction

    function void check_result(hhlp_out_t got);
        hhlp_out_t want;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected result: kind %0d byte %02h pos %0d count %0d",
                         got.byte_kind, got.echo_byte, got.field_position, got.headers_done);
            end
            return;
        end
        want = expected_results.pop_front();
        if (got.byte_kind !== want.byte_kind || got.echo_byte !== want.echo_byte ||
            got.field_position !== want.field_position ||
            got.headers_done !== want.headers_done ||
            got.is_block_end !== want.is_block_end ||
            got.block_status !== want.block_status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch: expected kind %0d byte %02h pos %0d count %0d end %0b st %0b",
                         want.byte_kind, want.echo_byte, want.field_position,
                         want.headers_done, want.is_block_end, want.block_status);
                $display("          got      kind %0d byte %02h pos %0d count %0d end %0b st %0b",
                         got.byte_kind, got.echo_byte, got.field_position,
                         got.headers_done, got.is_block_end, got.block_status);
            end
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module tb_top;
    import hhlp_pkg::*;

    localparam int KEY_BOUND = 256;
    localparam int VALUE_BOUND = 4096;
    localparam int MAX_HEADERS = 32;

    localparam int CYCLE_LIMIT = 400000;
    localparam int STALL_CYCLES = 300;
    localparam int TOTAL_ITEMS = 1350;
    localparam int RANDOM_PHASES = 9;
    localparam int SETTLE_CYCLES = 20;

    // Deliberate defects that the header generator can plant.
    typedef enum int {
        FLAW_NONE,
        FLAW_EMPTY_KEY,
        FLAW_SPACE_BEFORE_COLON,
        FLAW_CTRL_IN_KEY,
        FLAW_NO_LEADING_SPACE,
        FLAW_BARE_LF,
        FLAW_LF_AFTER_SPACE,
        FLAW_NOISE_BYTE
    } flaw_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    hhlp_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    hhlp_out_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    header_line_scoreboard sb;

    int         send_idle_pct;
    int         recv_idle_pct;
    int         stall_asks;
    int         stall_seen;
    int         stall_left;
    int         cycle_count;
    logic [7:0] line_buf[$];

    http_header_line_parser #(
        .KEY_BOUND  (KEY_BOUND),
        .VALUE_BOUND(VALUE_BOUND),
        .MAX_HEADERS(MAX_HEADERS)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Both handshakes are observed in one place so that prediction always
    // precedes checking.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_asks != stall_seen) begin
                stall_seen = stall_asks;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one byte and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
        hhlp_in_t item;
        item.data_byte = b;
        item.block_start = st;
        item.block_end = en;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic send_block(input bit with_start, input int last_idx, input bit with_end);
        for (int i = 0; i <= last_idx; i++) begin
            send_byte(line_buf[i], with_start && i == 0, with_end && i == last_idx);
        end
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
    endtask

    // One APB write; the bus is returned to idle before the next access.
    task automatic write_reg(input logic reg_sel, input int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        if (reg_sel == REG_KEY_LIMIT) begin
            sb.key_limit = value[KEY_LIMIT_W-1:0];
        end else begin
            sb.value_limit = value[VALUE_LIMIT_W-1:0];
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_limits(input int key_lim, input int value_lim);
        wait_drained();
        write_reg(REG_KEY_LIMIT, key_lim);
        write_reg(REG_VALUE_LIMIT, value_lim);
    endtask

    function automatic logic [7:0] key_char();
        logic [7:0] c;
        if ($urandom_range(11) == 0) begin
            return CHAR_SPACE;
        end
        c = 8'($urandom_range(33, 126));
        if (c == CHAR_COLON) begin
            c = 8'h2D;
        end
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == CHAR_LF) begin
            c = CHAR_COLON;
        end
        return c;
    endfunction

    // Append one "key: value CR LF" line, possibly with a planted defect.
    function automatic void add_header(input int klen, input int vlen, input flaw_t flaw);
        int         first;
        logic [7:0] c;
        first = line_buf.size();
        if (flaw == FLAW_EMPTY_KEY) begin
            klen = 0;
        end else if (klen < 1) begin
            klen = 1;
        end
        for (int i = 0; i < klen; i++) begin
            c = key_char();
            if (flaw == FLAW_SPACE_BEFORE_COLON && i == klen - 1) begin
                c = CHAR_SPACE;
            end else if (flaw == FLAW_CTRL_IN_KEY && i == klen / 2) begin
                c = $urandom_range(1) ? CHAR_CR : CHAR_LF;
            end
            line_buf.push_back(c);
        end
        line_buf.push_back(CHAR_COLON);
        line_buf.push_back(flaw == FLAW_NO_LEADING_SPACE ? value_char() : CHAR_SPACE);
        if (flaw == FLAW_LF_AFTER_SPACE) begin
            line_buf.push_back(CHAR_LF);
            return;
        end
        for (int i = 0; i < vlen; i++) begin
            line_buf.push_back(value_char());
        end
        if (flaw != FLAW_BARE_LF) begin
            line_buf.push_back(CHAR_CR);
        end
        line_buf.push_back(CHAR_LF);
        if (flaw == FLAW_NOISE_BYTE) begin
            line_buf[first + $urandom_range(line_buf.size() - first - 1)] =
                8'($urandom_range(255));
        end
    endfunction

    // One random block: mostly well-formed headers with random content,
    // some defects, some raw noise, and some blocks cut short.
    task automatic send_random_block();
        int    n_headers;
        int    klen;
        int    vlen;
        int    kcap;
        int    vcap;
        int    last_idx;
        flaw_t flaw;
        bit    with_start;
        bit    with_end;
        line_buf.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
            return;
        end
        kcap = (sb.key_limit > 40) ? 40 : sb.key_limit;
        vcap = (sb.value_limit > 40) ? 40 : sb.value_limit;
        n_headers = $urandom_range(0, 4);
        for (int h = 0; h < n_headers; h++) begin
            klen = ($urandom_range(9) == 0) ? $urandom_range(1, kcap + 2) : $urandom_range(1, 10);
            vlen = ($urandom_range(9) == 0) ? $urandom_range(0, vcap + 2) : $urandom_range(0, 12);
            flaw = ($urandom_range(99) < 85) ? FLAW_NONE : flaw_t'($urandom_range(1, 7));
            add_header(klen, vlen, flaw);
        end
        // An HTTP-style blank line closing the block.
        if ($urandom_range(3) == 0) begin
            line_buf.push_back(CHAR_CR);
            line_buf.push_back(CHAR_LF);
        end
        if (line_buf.size() == 0) begin
            line_buf.push_back(key_char());
        end
        last_idx = line_buf.size() - 1;
        if ($urandom_range(9) == 0) begin
            last_idx = $urandom_range(last_idx);
        end
        with_start = ($urandom_range(9) != 0);
        with_end = ($urandom_range(9) != 0);
        send_block(with_start, last_idx, with_end);
    endtask

    task automatic send_header_block(input int n_headers, input int klen, input int vlen);
        line_buf.delete();
        repeat (n_headers) begin
            add_header(klen, vlen, FLAW_NONE);
        end
        send_block(1'b1, line_buf.size() - 1, 1'b1);
    endtask

    function automatic int pick_key_limit();
        case ($urandom_range(5))
            0: return 1;
            1: return KEY_BOUND;
            2: return 0;
            3: return 511;
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    function automatic int pick_value_limit();
        case ($urandom_range(5))
            0: return 2;
            1: return VALUE_BOUND;
            2: return 0;
            3: return 8191;
            default: return $urandom_range(2, 48);
        endcase
    endfunction

    initial begin
        int base;
        int budget;
        sb = new(KEY_BOUND, VALUE_BOUND, MAX_HEADERS);
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 6;
        recv_idle_pct = 47;
        stall_asks = 0;
        stall_seen = 0;
        stall_left = 0;
        cycle_count = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed blocks at the reset limits: a complete header with extreme
        // value bytes, then several malformed forms, each on its own.
        line_buf = '{8'h41, 8'h62, CHAR_COLON, CHAR_SPACE, 8'hFF, 8'h00, CHAR_CR, CHAR_LF};
        send_block(1'b1, line_buf.size() - 1, 1'b1);
        // Empty key; the byte after the error is ignored.
        line_buf = '{CHAR_COLON, 8'h78};
        send_block(1'b1, line_buf.size() - 1, 1'b1);
        // Space before the colon.
        line_buf = '{8'h6B, CHAR_SPACE, CHAR_COLON};
        send_block(1'b1, line_buf.size() - 1, 1'b1);
        // CR in the key; the previous block end alone starts this block.
        line_buf = '{8'h6B, CHAR_CR};
        send_block(1'b0, line_buf.size() - 1, 1'b1);
        // LF as the very first key byte.
        line_buf = '{CHAR_LF};
        send_block(1'b1, 0, 1'b1);
        // Missing leading space.
        line_buf = '{8'h6B, CHAR_COLON, 8'h78};
        send_block(1'b1, line_buf.size() - 1, 1'b1);
        // LF right after the leading space.
        line_buf = '{8'h6B, CHAR_COLON, CHAR_SPACE, CHAR_LF};
        send_block(1'b1, line_buf.size() - 1, 1'b1);

        // Header table: exactly full, then one header too many.
        send_header_block(MAX_HEADERS, 1, 0);
        line_buf.delete();
        repeat (MAX_HEADERS + 1) begin
            add_header(1, 0, FLAW_NONE);
        end
        add_header(2, 2, FLAW_NONE);
        send_block(1'b1, line_buf.size() - 1, 1'b1);

        // Smallest limits: even a one-byte key cannot be closed by its colon.
        set_limits(1, 2);
        send_header_block(1, 1, 0);
        send_header_block(1, 2, 0);
        repeat (2) send_random_block();

        // A key limit above the bound saturates to the bound: the key byte at
        // the bound position is malformed.
        set_limits(511, 8191);
        send_header_block(1, KEY_BOUND + 1, 1);

        // A zero limit makes the first byte of that phase malformed.
        set_limits(0, 1024);
        repeat (2) send_random_block();
        set_limits(12, 0);
        repeat (2) send_random_block();

        // Random phases, each with its own limits; the idle mix moves from
        // sender-light to receiver-light to none, with one long hold-off each.
        budget = (TOTAL_ITEMS - sb.accepted_count) / RANDOM_PHASES;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_limits(pick_key_limit(), pick_value_limit());
            case (ph * 3 / RANDOM_PHASES)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph % 3 == 0) begin
                stall_asks++;
            end
            base = sb.accepted_count;
            while (sb.accepted_count - base < budget) begin
                send_random_block();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
